FILE: hdl/button_press_long_repeat_fsm_defines.svh
// Assertion macros shared by the button state machine RTL.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef BUTTON_PRESS_LONG_REPEAT_FSM_DEFINES_SVH
`define BUTTON_PRESS_LONG_REPEAT_FSM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bpl_pkg.sv
// Shared types and constants for the button press / long press / repeat block.
// No dependencies.
package bpl_pkg;

   localparam int TimeWidth   = 32;
   localparam int PeriodWidth = 16;
   localparam int CountWidth  = 4;
   localparam int CodeWidth   = 3;
   localparam int CsrIdxWidth = 3;

   // register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_IDLE_POLL   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_LONG_PRESS  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_REPEAT      = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_BLINK_PER   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_BLINK_LIMIT = 3'd5;

   // reset values of the timing registers
   localparam logic [PeriodWidth-1:0] RST_IDLE_POLL   = 16'd10;
   localparam logic [PeriodWidth-1:0] RST_DEBOUNCE    = 16'd20;
   localparam logic [PeriodWidth-1:0] RST_LONG_PRESS  = 16'd500;
   localparam logic [PeriodWidth-1:0] RST_REPEAT      = 16'd250;
   localparam logic [PeriodWidth-1:0] RST_BLINK_PER   = 16'd100;
   localparam logic [CountWidth-1:0]  RST_BLINK_LIMIT = 4'd6;

   // event codes on the result channel
   localparam logic [CodeWidth-1:0] EV_NONE  = 3'd0;
   localparam logic [CodeWidth-1:0] EV_PRESS = 3'd1;
   localparam logic [CodeWidth-1:0] EV_LONG  = 3'd2;
   localparam logic [CodeWidth-1:0] EV_RPT   = 3'd3;
   localparam logic [CodeWidth-1:0] EV_BLINK = 3'd4;

   typedef struct packed {
      logic [PeriodWidth-1:0] idle_poll_period;
      logic [PeriodWidth-1:0] debounce_time;
      logic [PeriodWidth-1:0] long_press_time;
      logic [PeriodWidth-1:0] repeat_period;
      logic [PeriodWidth-1:0] blink_period;
      logic [CountWidth-1:0]  blink_limit;
   } cfg_type;

endpackage

FILE: hdl/button_press_long_repeat_fsm.sv
// Button press / long press / repeat / release-blink block, top level.
// Depends on bpl_pkg, bpl_csr, bpl_core and button_press_long_repeat_fsm_defines.svh.
//
// Each req transaction is one poll: tdata carries now_ms (bits 31:0) and
// pin_level (bit 32). Every poll yields exactly one rsp transaction whose
// tdata carries event_code (bits 2:0) and the state after the poll (bits 5:3).
// The csr port writes the six timing registers by index, one per cycle when
// csr_wen is high; write them only while no poll is in flight.
//
// A poll accepted into the input register is processed into the result register
// when the result stage is empty or being drained; rsp_tvalid is the valid bit
// of the result register. Throughput is one poll per cycle while rsp_tready
// is high: the state update is combinational subtract-compare logic and a mux
// between those two registers, so a new poll can enter every cycle.
// When rsp_tready is low the result is held and the input register still
// takes one poll; req_tready drops only once both stages are full.
// Synchronous reset returns the machine to idle with zero timestamps and
// blink count, loads the default timing values and empties both stages.
`include "button_press_long_repeat_fsm_defines.svh"

module button_press_long_repeat_fsm
   import bpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,   // now_ms[31:0], pin_level[32], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // event_code[2:0], fsm_state[5:3], zero pad
   input  logic                   csr_wen,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [PeriodWidth-1:0] csr_wdata
);

   cfg_type              cfg;
   logic                 in_valid_ff, in_valid_in;
   logic [TimeWidth-1:0] now_ff;
   logic                 pin_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CodeWidth-1:0] event_ff, state_out_ff;
   logic [CodeWidth-1:0] event_code, fsm_state;
   logic                 advance, step, req_fire;

   // result stage can take a new value when empty or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff <= req_tdata[TimeWidth-1:0];
         pin_ff <= req_tdata[TimeWidth];
      end
      if (step) begin
         event_ff     <= event_code;
         state_out_ff <= fsm_state;
      end
   end

   bpl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .now_ms     (now_ff),
      .pin_level  (pin_ff),
      .cfg        (cfg),
      .event_code (event_code),
      .fsm_state  (fsm_state)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, state_out_ff, event_ff};

   `BPL_ASSERT_NXT(a_input_held, in_valid_ff && !advance, in_valid_ff && $stable(now_ff), "stalled poll was lost")
   `BPL_ASSERT_NXT(a_step_fills_rsp, step, rsp_valid_ff, "processed poll produced no result")
   `BPL_ASSERT_IMP(a_no_accept_when_full, in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready, "accept while both stages full")

endmodule

FILE: hdl/bpl_csr.sv
// Configuration registers of the button state machine.
// Depends on bpl_pkg.
module bpl_csr
   import bpl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [PeriodWidth-1:0] csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_IDLE_POLL:   cfg_in.idle_poll_period = csr_wdata;
            CSR_DEBOUNCE:    cfg_in.debounce_time    = csr_wdata;
            CSR_LONG_PRESS:  cfg_in.long_press_time  = csr_wdata;
            CSR_REPEAT:      cfg_in.repeat_period    = csr_wdata;
            CSR_BLINK_PER:   cfg_in.blink_period     = csr_wdata;
            CSR_BLINK_LIMIT: cfg_in.blink_limit      = csr_wdata[CountWidth-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_poll_period <= RST_IDLE_POLL;
         cfg_ff.debounce_time    <= RST_DEBOUNCE;
         cfg_ff.long_press_time  <= RST_LONG_PRESS;
         cfg_ff.repeat_period    <= RST_REPEAT;
         cfg_ff.blink_period     <= RST_BLINK_PER;
         cfg_ff.blink_limit      <= RST_BLINK_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/bpl_core.sv
// Five-state button machine: holds state and timestamps, decides the event per poll.
// Depends on bpl_pkg and button_press_long_repeat_fsm_defines.svh.
`include "button_press_long_repeat_fsm_defines.svh"

module bpl_core
   import bpl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [TimeWidth-1:0] now_ms,
   input  logic                 pin_level,
   input  cfg_type              cfg,
   output logic [CodeWidth-1:0] event_code,
   output logic [CodeWidth-1:0] fsm_state
);

   typedef enum logic [CodeWidth-1:0] {
      ST_IDLE     = 3'd0,
      ST_DEBOUNCE = 3'd1,
      ST_PRESSED  = 3'd2,
      ST_REPEAT   = 3'd3,
      ST_RELEASE  = 3'd4
   } state_type;

   state_type              state_ff, state_in;
   logic [TimeWidth-1:0]   last_event_ff, last_event_in;
   logic [TimeWidth-1:0]   last_blink_ff, last_blink_in;
   logic [CountWidth-1:0]  blink_count_ff, blink_count_in;
   logic [CodeWidth-1:0]   ev;

   logic [TimeWidth-1:0]   since_event;
   logic [TimeWidth-1:0]   since_blink;
   logic [PeriodWidth-1:0] event_period;
   logic                   event_due;
   logic                   blink_due;

   // wrapping differences against the stored timestamps
   assign since_event = now_ms - last_event_ff;
   assign since_blink = now_ms - last_blink_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE:     event_period = cfg.idle_poll_period;
         ST_DEBOUNCE: event_period = cfg.debounce_time;
         ST_PRESSED:  event_period = cfg.long_press_time;
         ST_REPEAT:   event_period = cfg.repeat_period;
         default:     event_period = cfg.idle_poll_period;
      endcase
   end

   assign event_due = since_event >= {{(TimeWidth-PeriodWidth){1'b0}}, event_period};
   assign blink_due = since_blink >= {{(TimeWidth-PeriodWidth){1'b0}}, cfg.blink_period};

   always_comb begin
      state_in       = state_ff;
      last_event_in  = last_event_ff;
      last_blink_in  = last_blink_ff;
      blink_count_in = blink_count_ff;
      ev             = EV_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (event_due) begin
               state_in      = pin_level ? ST_DEBOUNCE : ST_IDLE;
               last_event_in = now_ms;
            end
         end
         ST_DEBOUNCE: begin
            if (!pin_level) begin
               state_in = ST_IDLE;
            end else if (event_due) begin
               ev            = EV_PRESS;
               state_in      = ST_PRESSED;
               last_event_in = now_ms;
            end
         end
         ST_PRESSED: begin
            if (!pin_level) begin
               state_in = ST_RELEASE;
            end else if (event_due) begin
               ev            = EV_LONG;
               state_in      = ST_REPEAT;
               last_event_in = now_ms;
            end
         end
         ST_REPEAT: begin
            if (!pin_level) begin
               state_in = ST_RELEASE;
            end else if (event_due) begin
               ev            = EV_RPT;
               last_event_in = now_ms;
            end
         end
         ST_RELEASE: begin
            // re-press goes back to debounce without refreshing the event time
            if (pin_level) begin
               state_in = ST_DEBOUNCE;
            end else if (blink_count_ff < cfg.blink_limit) begin
               if (blink_due) begin
                  ev             = EV_BLINK;
                  blink_count_in = blink_count_ff + 1'b1;
                  last_blink_in  = now_ms;
               end
            end else begin
               state_in       = ST_IDLE;
               blink_count_in = '0;
            end
         end
         default: begin
            ev = EV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_event_ff  <= '0;
         last_blink_ff  <= '0;
         blink_count_ff <= '0;
      end else if (step) begin
         state_ff       <= state_in;
         last_event_ff  <= last_event_in;
         last_blink_ff  <= last_blink_in;
         blink_count_ff <= blink_count_in;
      end
   end

   assign event_code = ev;
   assign fsm_state  = state_in;

   `BPL_ASSERT_NXT(a_hold_when_idle, !step, $stable(state_ff) && $stable(blink_count_ff), "state moved without a poll")
   `BPL_ASSERT_NXT(a_blink_counts, step && (ev == EV_BLINK), blink_count_ff == $past(blink_count_ff) + 1'b1, "blink count did not advance")
   `BPL_ASSERT_NXT(a_press_stamps, step && (ev == EV_PRESS), (state_ff == ST_PRESSED) && (last_event_ff == $past(now_ms)), "press did not stamp time")
   `BPL_ASSERT_IMP(a_blink_only_release, ev == EV_BLINK, state_ff == ST_RELEASE, "blink outside release")

endmodule
